// ===== sv/olve_pkg.sv =====
// Shared constants, types and status codes for the ordered value list engine.
// No dependencies.
package olve_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [2:0]              t_status;
    typedef logic [1:0]              t_req;

    localparam t_req REQ_INSERT  = 2'd0;
    localparam t_req REQ_DELETE  = 2'd1;
    localparam t_req REQ_READOUT = 2'd2;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_DELETED  = 3'd1;
    localparam t_status ST_NOTFOUND = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_FULL     = 3'd4;
    localparam t_status ST_ELEMENT  = 3'd5;

endpackage

// ===== sv/olve_if.sv =====
// Request and result channel interfaces, valid/ready handshake.
// Depends on olve_pkg.
interface olve_in_if
    import olve_pkg::*;
();
    logic  valid;
    logic  ready;
    t_req  req_type;
    t_val  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface olve_out_if
    import olve_pkg::*;
();
    logic    valid;
    logic    ready;
    t_status status;
    t_val    value_res;
    logic    last;

    modport source (output valid, output status, output value_res, output last, input ready);
    modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

// ===== sv/olve_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module olve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [WIDTH-1:0]              i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/ordered_value_list_engine_core.sv =====
// Ordered value list engine: circular linked list of signed words in a slot pool.
// Insert: a pass through S_LINK (a second pass when the list was not empty), then S_REPLY loads the output register.
// Delete and read-out: S_IDLE starts the walk, then S_WALK visits one slot per cycle (one read of the
// value and link memories per cycle; read-out stalls while the output register cannot take a word).
// Synchronous active-low reset empties the list and frees every slot; memories are not cleared.
// Depends on olve_pkg, olve_if and olve_ram.
module ordered_value_list_engine_core
    import olve_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    olve_in_if.sink          i_in,
    olve_out_if.source       o_out
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LINK  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_REPLY = 2'd3;

    logic [1:0]          r_state, n_state;
    t_idx                r_head, n_head;
    t_idx                r_tail, n_tail;
    t_cnt                r_count, n_count;
    logic [CAPACITY-1:0] r_free, n_free;
    t_idx                r_cur, n_cur;
    t_idx                r_prev, n_prev;
    t_cnt                r_n, n_n;
    t_req                r_req, n_req;
    t_val                r_val, n_val;
    t_status             r_rst, n_rst;

    logic    r_ov, n_ov;
    t_status r_ost, n_ost;
    t_val    r_oval, n_oval;
    logic    r_olast, n_olast;

    logic    out_free;
    logic    emit;
    t_status emit_st;
    t_val    emit_val;
    logic    emit_last;

    logic    ram_re;
    t_idx    ram_raddr;
    logic    val_we;
    t_idx    val_waddr;
    t_val    val_rdata;
    logic    nxt_we;
    t_idx    nxt_waddr;
    t_idx    nxt_wdata;
    t_idx    nxt_rdata;

    t_idx    free_low;
    logic    accept;

    olve_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_val),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (val_rdata)
    );

    olve_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (nxt_rdata)
    );

    always_comb begin
        free_low = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_low = t_idx'(i);
            end
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid & i_in.ready;
    assign out_free   = !r_ov || o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_free    = r_free;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_n       = r_n;
        n_req     = r_req;
        n_val     = r_val;
        n_rst     = r_rst;
        emit      = 1'b0;
        emit_st   = r_rst;
        emit_val  = r_val;
        emit_last = 1'b1;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        val_we    = 1'b0;
        val_waddr = free_low;
        nxt_we    = 1'b0;
        nxt_waddr = free_low;
        nxt_wdata = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_in.req_type;
                    n_val = i_in.value;
                    case (i_in.req_type)
                        REQ_INSERT: begin
                            if (r_free == '0) begin
                                n_rst   = ST_FULL;
                                n_state = S_REPLY;
                            end else begin
                                // value RAM writes r_val, so the word is written from S_LINK once r_val holds it
                                n_cur   = free_low;
                                n_free  = r_free & ~(CAPACITY'(1) << free_low);
                                n_count = r_count + t_cnt'(1);
                                n_rst   = ST_INSERTED;
                                n_state = S_LINK;
                            end
                        end
                        REQ_DELETE, REQ_READOUT: begin
                            if (r_count == '0) begin
                                n_rst   = ST_EMPTY;
                                n_state = S_REPLY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_cur     = r_head;
                                n_prev    = r_tail;
                                n_n       = t_cnt'(1);
                                n_state   = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_LINK: begin
                val_we    = 1'b1;
                val_waddr = r_cur;
                nxt_we    = 1'b1;
                nxt_waddr = r_cur;
                if (r_count == t_cnt'(1)) begin
                    nxt_wdata = r_cur;
                    n_head    = r_cur;
                    n_tail    = r_cur;
                    n_state   = S_REPLY;
                end else if (r_n != '0) begin
                    // second pass: hook the old tail to the new slot
                    nxt_waddr = r_tail;
                    nxt_wdata = r_cur;
                    val_we    = 1'b0;
                    n_tail    = r_cur;
                    n_n       = '0;
                    n_state   = S_REPLY;
                end else begin
                    nxt_wdata = r_head;
                    n_n       = t_cnt'(1);
                end
            end

            S_WALK: begin
                if (r_req == REQ_DELETE) begin
                    if (val_rdata == r_val) begin
                        n_free  = r_free | (CAPACITY'(1) << r_cur);
                        n_count = r_count - t_cnt'(1);
                        n_rst   = ST_DELETED;
                        n_state = S_REPLY;
                        if (r_count == t_cnt'(1)) begin
                            n_head = '0;
                        end else begin
                            nxt_we    = 1'b1;
                            nxt_waddr = r_prev;
                            nxt_wdata = nxt_rdata;
                            if (r_cur == r_head) begin
                                n_head = nxt_rdata;
                            end
                            if (r_cur == r_tail) begin
                                n_tail = r_prev;
                            end
                        end
                    end else if (r_n == r_count) begin
                        n_rst   = ST_NOTFOUND;
                        n_state = S_REPLY;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = nxt_rdata;
                        n_prev    = r_cur;
                        n_cur     = nxt_rdata;
                        n_n       = r_n + t_cnt'(1);
                    end
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_st   = ST_ELEMENT;
                    emit_val  = val_rdata;
                    emit_last = (r_n == r_count);
                    if (r_n == r_count) begin
                        n_n     = '0;
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = nxt_rdata;
                        n_cur     = nxt_rdata;
                        n_n       = r_n + t_cnt'(1);
                    end
                end
            end

            S_REPLY: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_n     = '0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov    = r_ov;
        n_ost   = r_ost;
        n_oval  = r_oval;
        n_olast = r_olast;
        if (emit) begin
            n_ov    = 1'b1;
            n_ost   = emit_st;
            n_oval  = emit_val;
            n_olast = emit_last;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_free  <= '1;
            r_n     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_free  <= n_free;
            r_n     <= n_n;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_req   <= n_req;
        r_val   <= n_val;
        r_rst   <= n_rst;
        r_ost   <= n_ost;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    assign o_out.valid     = r_ov;
    assign o_out.status    = r_ost;
    assign o_out.value_res = r_oval;
    assign o_out.last      = r_olast;
endmodule

// ===== dv/ordered_value_list_engine_core_tb.sv =====
// Self-checking testbench for ordered_value_list_engine_core: random and directed
// insert, delete and read-out requests, checked against a queue-based list predictor.
// Depends on olve_pkg, olve_if and the engine RTL.
module ordered_value_list_engine_core_tb
    import olve_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_req REQ_UNUSED   = 2'd3;
    localparam t_val VAL_MIN      = 32'sh8000_0000;
    localparam t_val VAL_MAX      = 32'sh7fff_ffff;
    localparam int   DRAIN_CYCLES = 2 * CAPACITY + 16;
    localparam int   CYCLE_LIMIT  = 800000;
    localparam int   REPORT_MAX   = 10;

    typedef struct packed {
        t_status status;
        t_val    value;
        logic    last;
    } t_list_word;

    class value_list_checker;
        t_val       shadow_list[$];
        t_list_word due_words[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function void apply_request(t_req req, t_val val);
            t_list_word w;
            int         hit;
            hit = -1;
            case (req)
                REQ_INSERT: begin
                    if (shadow_list.size() >= CAPACITY) begin
                        w = '{ST_FULL, val, 1'b1};
                    end else begin
                        shadow_list.push_back(val);
                        w = '{ST_INSERTED, val, 1'b1};
                    end
                    due_words.push_back(w);
                end
                REQ_DELETE: begin
                    foreach (shadow_list[i])
                        if (hit < 0 && shadow_list[i] == val) hit = i;
                    if (shadow_list.size() == 0) begin
                        w = '{ST_EMPTY, val, 1'b1};
                    end else if (hit < 0) begin
                        w = '{ST_NOTFOUND, val, 1'b1};
                    end else begin
                        shadow_list.delete(hit);
                        w = '{ST_DELETED, val, 1'b1};
                    end
                    due_words.push_back(w);
                end
                REQ_READOUT: begin
                    if (shadow_list.size() == 0) begin
                        w = '{ST_EMPTY, val, 1'b1};
                        due_words.push_back(w);
                    end else begin
                        foreach (shadow_list[i]) begin
                            w = '{ST_ELEMENT, shadow_list[i], i == shadow_list.size() - 1};
                            due_words.push_back(w);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(t_status st, t_val v, logic lst);
            t_list_word w;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected word: status %0d value %0d last %0b", st, v, lst);
                return;
            end
            w = due_words.pop_front();
            if (w.status !== st || w.value !== v || w.last !== lst) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: expected status %0d value %0d last %0b, got %0d %0d %0b",
                             w.status, w.value, w.last, st, v, lst);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   rx_hold;
    int   cycle_count;

    value_list_checker sb;

    olve_in_if  in_if ();
    olve_out_if out_if ();

    ordered_value_list_engine_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            out_if.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_word(out_if.status, out_if.value_res, out_if.last);

    task automatic send_word(input t_req req, input t_val val);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid    <= 1'b0;
            in_if.req_type <= t_req'($urandom);
            in_if.value    <= t_val'($urandom);
            @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.req_type <= req;
        in_if.value    <= val;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.apply_request(req, val);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.due_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_val pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40) return t_val'(int'($urandom_range(8)) - 4);
        if (r < 50) begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return t_val'($urandom);
    endfunction

    function automatic t_val delete_value();
        int n;
        n = sb.shadow_list.size();
        if (n > 0 && $urandom_range(99) < 70)
            return sb.shadow_list[$urandom_range(n - 1)];
        return pick_value();
    endfunction

    task automatic run_mix(input int n, input int ins_pct, input int del_pct);
        int sent;
        int r;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < ins_pct) begin
                send_word(REQ_INSERT, pick_value());
                sent++;
            end else if (r < ins_pct + del_pct) begin
                send_word(REQ_DELETE, delete_value());
                sent++;
            end else if (r < 97) begin
                send_word(REQ_READOUT, t_val'($urandom));
                sent++;
            end else begin
                send_word(REQ_UNUSED, t_val'($urandom));
            end
        end
    endtask

    initial begin
        in_if.valid    = 1'b0;
        in_if.req_type = REQ_INSERT;
        in_if.value    = '0;
        out_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold        = 0;
        cycle_count    = 0;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(REQ_READOUT, 32'sh1234_5678);
        send_word(REQ_DELETE,  VAL_MIN);
        send_word(REQ_INSERT,  VAL_MIN);
        send_word(REQ_INSERT,  VAL_MAX);
        send_word(REQ_INSERT,  '0);
        send_word(REQ_INSERT,  '1);
        send_word(REQ_INSERT,  32'sd5);
        send_word(REQ_INSERT,  32'sd5);
        send_word(REQ_READOUT, '0);
        send_word(REQ_DELETE,  32'sd12345);
        send_word(REQ_DELETE,  VAL_MIN);
        send_word(REQ_DELETE,  '0);
        send_word(REQ_DELETE,  32'sd5);
        send_word(REQ_READOUT, '1);
        send_word(REQ_DELETE,  32'sd5);
        send_word(REQ_UNUSED,  32'shdead_beef);
        send_word(REQ_DELETE,  VAL_MAX);
        send_word(REQ_DELETE,  '1);
        send_word(REQ_READOUT, VAL_MAX);
        send_word(REQ_DELETE,  '1);
        send_word(REQ_INSERT,  32'sh5555_5555);
        send_word(REQ_INSERT,  32'shaaaa_aaaa);
        send_word(REQ_READOUT, VAL_MIN);
        pause_until_drained();

        // hold the result side off so the engine backs up into its input
        rx_hold = 500;
        repeat (36) send_word(REQ_INSERT, pick_value());
        repeat (3) send_word(REQ_READOUT, t_val'($urandom));
        pause_until_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            run_mix(28, 15, 75);
            run_mix(28, 70, 20);
            run_mix(16, 40, 40);
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
